// ----- src/sst_pkg.sv -----
// Shared types and constants for the surrogate straddle tracker.
// Used by sst_front, sst_back and the top level; depends on nothing.
package sst_pkg;

	localparam int BIN_W = 10;
	localparam int VAL_W = 20;
	localparam int CNT_W = 17;
	localparam int NB_W = 11;
	localparam int EP_W = 4;
	localparam int IN_DATA_W = 56;
	localparam int OUT_DATA_W = 32;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam int MAX_BINS_DEF = 1024;
	localparam logic [NB_W-1:0] NUM_BINS_RST = 11'd1024;
	localparam logic [CNT_W-1:0] MAX_SURR_RST = 17'd105178;

	localparam logic CMD_CLEAR = 1'b0;

	localparam logic REG_NUM_BINS = 1'b0;
	localparam logic REG_MAX_SURR = 1'b1;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_SAMPLE = 2'd1;
	localparam logic [1:0] KIND_OUTSIDE = 2'd2;

	localparam logic [1:0] BS_PENDING = 2'd0;
	localparam logic [1:0] BS_STRADDLED = 2'd1;
	localparam logic [1:0] BS_DONE = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [BIN_W-1:0] bin_index;
		logic [VAL_W-1:0] data_value;
		logic [VAL_W-1:0] surrogate_value;
		logic last_bin;
	} item_t;

	typedef struct packed {
		logic [EP_W-1:0] tag;
		logic done;
		logic [CNT_W-1:0] number;
	} entry_t;

endpackage

// ----- src/surrogate_straddle_tracker_core.sv -----
// A queued word is read with its bin memory entry and its result word is registered once
// the output can take it; the back part takes the next word only then, as the bin memory
// is read-modify-written. Reset is asynchronous and active low; it restores the register
// defaults and starts a pass over all MAX_BINS entries that clears the bin memory, during
// which no input word is taken. The same pass follows every sixteenth clear, when the
// clear epoch wraps. Top level; depends on sst_pkg, sst_front and sst_back.
module surrogate_straddle_tracker_core #(
	parameter int MAX_BINS = sst_pkg::MAX_BINS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [sst_pkg::IN_DATA_W-1:0] s_tdata, // bin_index, data_value, surrogate_value, zero pad
	input  logic s_tuser, // cmd
	input  logic s_tlast, // last_bin
	output logic m_tvalid,
	input  logic m_tready,
	output logic [sst_pkg::OUT_DATA_W-1:0] m_tdata, // bin_state, straddle_number, pending_bins,
	                                                // all_done, limit_reached
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [sst_pkg::CNT_W-1:0] cfg_data
);

	localparam int EW = ($clog2(MAX_BINS + 1) > sst_pkg::NB_W) ?
		$clog2(MAX_BINS + 1) : sst_pkg::NB_W;

	logic q_valid;
	logic q_ready;
	sst_pkg::item_t q_item;
	logic [EW-1:0] active_bins;
	logic hold;

	sst_front #(
		.MAX_BINS(MAX_BINS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.active_bins(active_bins),
		.hold(hold),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_item(q_item)
	);

	sst_back #(
		.MAX_BINS(MAX_BINS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_item(q_item),
		.active_bins(active_bins),
		.hold(hold),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

endmodule

// ----- src/sst_front.sv -----
// Front part of the tracker: accepts input words, classifies them and queues them.
// Depends on sst_pkg; active_bins and hold come from sst_back.
module sst_front #(
	parameter int MAX_BINS = sst_pkg::MAX_BINS_DEF,
	localparam int EW = ($clog2(MAX_BINS + 1) > sst_pkg::NB_W) ?
		$clog2(MAX_BINS + 1) : sst_pkg::NB_W
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [sst_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic s_tuser,
	input  logic s_tlast,
	input  logic [EW-1:0] active_bins,
	input  logic hold,
	output logic q_valid,
	input  logic q_ready,
	output sst_pkg::item_t q_item
);

	sst_pkg::item_t queue_q [sst_pkg::QDEPTH];
	logic [sst_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [sst_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [sst_pkg::QCNT_W-1:0] count_q;
	sst_pkg::item_t in_item;
	logic push;
	logic pop;

	always_comb begin
		in_item.bin_index = s_tdata[sst_pkg::BIN_W-1:0];
		in_item.data_value = s_tdata[sst_pkg::BIN_W +: sst_pkg::VAL_W];
		in_item.surrogate_value = s_tdata[sst_pkg::BIN_W + sst_pkg::VAL_W +: sst_pkg::VAL_W];
		in_item.last_bin = s_tlast;
		if (s_tuser == sst_pkg::CMD_CLEAR) begin
			in_item.kind = sst_pkg::KIND_CLEAR;
		end else if (EW'(s_tdata[sst_pkg::BIN_W-1:0]) < active_bins) begin
			in_item.kind = sst_pkg::KIND_SAMPLE;
		end else begin
			in_item.kind = sst_pkg::KIND_OUTSIDE;
		end
	end

	assign s_tready = (count_q != sst_pkg::QCNT_W'(sst_pkg::QDEPTH)) && !hold;
	assign push = s_tvalid && s_tready;
	assign q_valid = (count_q != '0);
	assign pop = q_valid && q_ready;
	assign q_item = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/sst_back.sv -----
// Back part of the tracker: bin memories, counters, configuration and result register.
// Depends on sst_pkg; takes queued words from sst_front.
module sst_back #(
	parameter int MAX_BINS = sst_pkg::MAX_BINS_DEF,
	localparam int IDX_W = $clog2(MAX_BINS),
	localparam int EW = ($clog2(MAX_BINS + 1) > sst_pkg::NB_W) ?
		$clog2(MAX_BINS + 1) : sst_pkg::NB_W
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	input  sst_pkg::item_t q_item,
	output logic [EW-1:0] active_bins,
	output logic hold,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [sst_pkg::CNT_W-1:0] cfg_data,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [sst_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam logic [1:0] ST_SWEEP = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	function automatic logic [EW-1:0] eff_bins(input logic [sst_pkg::NB_W-1:0] nb);
		logic [EW-1:0] r;
		if (nb == '0) begin
			r = EW'(1);
		end else if (EW'(nb) > EW'(MAX_BINS)) begin
			r = EW'(MAX_BINS);
		end else begin
			r = EW'(nb);
		end
		return r;
	endfunction

	sst_pkg::entry_t mem [MAX_BINS];
	logic sign_mem [MAX_BINS];

	logic [1:0] state_q;
	logic [IDX_W-1:0] sweep_addr_q;
	logic [sst_pkg::EP_W-1:0] epoch_q;
	logic [sst_pkg::NB_W-1:0] num_bins_q;
	logic [sst_pkg::CNT_W-1:0] max_surr_q;
	logic [sst_pkg::CNT_W-1:0] surr_count_q;
	logic [EW-1:0] pend_q;
	sst_pkg::item_t item_q;
	sst_pkg::entry_t rd_entry_q;
	logic rd_sign_q;
	logic out_valid_q;
	logic [sst_pkg::OUT_DATA_W-1:0] out_data_q;

	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] ex_addr;
	logic mem_we;
	logic [IDX_W-1:0] mem_wa;
	sst_pkg::entry_t mem_wd;
	logic sign_we;
	logic sign_wd;
	logic out_ok;
	logic fire;
	logic cfg_clear;
	logic do_clear;
	logic [sst_pkg::EP_W-1:0] epoch_nxt;
	logic hit;
	logic halted;
	logic finish;
	logic [sst_pkg::CNT_W-1:0] n_num;
	logic [sst_pkg::CNT_W-1:0] sc_nxt;
	logic [EW-1:0] pend_nxt;
	logic [1:0] res_state;
	logic [sst_pkg::CNT_W-1:0] res_number;

	assign active_bins = eff_bins(num_bins_q);
	assign hold = (state_q == ST_SWEEP);
	assign cfg_ready = 1'b1;
	assign q_ready = (state_q == ST_IDLE);
	assign out_ok = !out_valid_q || m_tready;
	assign fire = (state_q == ST_EXEC) && out_ok;
	assign cfg_clear = cfg_valid && (cfg_index == sst_pkg::REG_NUM_BINS);
	assign do_clear = cfg_clear || (fire && item_q.kind == sst_pkg::KIND_CLEAR);
	assign epoch_nxt = epoch_q + 1'b1;
	assign rd_addr = IDX_W'(q_item.bin_index);
	assign ex_addr = IDX_W'(item_q.bin_index);
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	always_comb begin
		hit = rd_entry_q.done && (rd_entry_q.tag == epoch_q);
		halted = (surr_count_q >= max_surr_q) || (pend_q == '0);
		n_num = (surr_count_q == '1) ? surr_count_q : surr_count_q + 1'b1;
		if (surr_count_q == '0) begin
			finish = (item_q.surrogate_value == item_q.data_value);
		end else if (rd_sign_q) begin
			finish = (item_q.surrogate_value >= item_q.data_value);
		end else begin
			finish = (item_q.surrogate_value <= item_q.data_value);
		end
		sc_nxt = surr_count_q;
		pend_nxt = pend_q;
		res_state = sst_pkg::BS_PENDING;
		res_number = '0;
		mem_we = 1'b0;
		mem_wa = ex_addr;
		mem_wd.tag = epoch_q;
		mem_wd.done = 1'b1;
		mem_wd.number = n_num;
		sign_we = 1'b0;
		sign_wd = (item_q.surrogate_value < item_q.data_value);
		if (item_q.kind == sst_pkg::KIND_CLEAR) begin
			sc_nxt = '0;
			pend_nxt = active_bins;
		end else if (halted) begin
			if (item_q.kind == sst_pkg::KIND_SAMPLE && hit) begin
				res_state = sst_pkg::BS_DONE;
				res_number = rd_entry_q.number;
			end
		end else begin
			if (item_q.kind == sst_pkg::KIND_SAMPLE) begin
				if (hit) begin
					res_state = sst_pkg::BS_DONE;
					res_number = rd_entry_q.number;
				end else if (finish) begin
					mem_we = fire;
					pend_nxt = pend_q - 1'b1;
					res_state = sst_pkg::BS_STRADDLED;
					res_number = n_num;
				end else begin
					sign_we = fire && (surr_count_q == '0);
				end
			end
			if (item_q.last_bin && surr_count_q != '1) begin
				sc_nxt = surr_count_q + 1'b1;
			end
		end
		if (state_q == ST_SWEEP) begin
			mem_we = 1'b1;
			mem_wa = sweep_addr_q;
			mem_wd = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (sign_we) begin
			sign_mem[ex_addr] <= sign_wd;
		end
		if (q_valid && q_ready) begin
			item_q <= q_item;
			rd_entry_q <= mem[rd_addr];
			rd_sign_q <= sign_mem[rd_addr];
		end
		if (fire) begin
			out_data_q <= {sc_nxt >= max_surr_q, pend_nxt == '0,
				pend_nxt[sst_pkg::NB_W-1:0], res_number, res_state};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			sweep_addr_q <= '0;
			epoch_q <= '0;
			num_bins_q <= sst_pkg::NUM_BINS_RST;
			max_surr_q <= sst_pkg::MAX_SURR_RST;
			surr_count_q <= '0;
			pend_q <= eff_bins(sst_pkg::NUM_BINS_RST);
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				if (cfg_index == sst_pkg::REG_NUM_BINS) begin
					num_bins_q <= cfg_data[sst_pkg::NB_W-1:0];
					surr_count_q <= '0;
					pend_q <= eff_bins(cfg_data[sst_pkg::NB_W-1:0]);
				end else begin
					max_surr_q <= cfg_data;
				end
			end
			if (fire) begin
				surr_count_q <= sc_nxt;
				pend_q <= pend_nxt;
			end
			if (do_clear) begin
				epoch_q <= epoch_nxt;
			end
			if (do_clear && epoch_nxt == '0) begin
				state_q <= ST_SWEEP;
				sweep_addr_q <= '0;
			end else begin
				case (state_q)
					ST_SWEEP: begin
						sweep_addr_q <= sweep_addr_q + 1'b1;
						if (sweep_addr_q == IDX_W'(MAX_BINS - 1)) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (q_valid) begin
							state_q <= ST_EXEC;
						end
					end
					ST_EXEC: begin
						if (fire) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

endmodule

// ----- dv/surrogate_straddle_tracker_core_tb.sv -----
// Self-checking testbench for surrogate_straddle_tracker_core: a directed table, then random
// histogram sweeps, each result checked against its table entry or a bin-tracking predictor.
// Depends on sst_pkg and the core; reads no files and needs no arguments.
module surrogate_straddle_tracker_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sst_pkg::*;

	localparam logic CMD_SAMPLE = ~CMD_CLEAR;
	localparam int NBINS = MAX_BINS_DEF;
	localparam logic [CNT_W-1:0] COUNT_TOP = '1;
	localparam int VAL_TOP = 20'hFFFFF;

	typedef struct packed {
		logic [1:0] bin_state;
		logic [CNT_W-1:0] number;
		logic [NB_W-1:0] pending;
		logic all_done;
		logic limit;
	} bin_report_t;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

	typedef struct {
		row_kind_e kind;
		logic reg_sel;
		logic [CNT_W-1:0] reg_val;
		logic cmd;
		int bin;
		int dat;
		int sur;
		logic last;
		bit typed;
		bin_report_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [CNT_W-1:0] cfg_data = '0;

	logic [NB_W-1:0] reg_num_bins;
	logic [CNT_W-1:0] reg_max_surr;
	logic [CNT_W-1:0] surr_count;
	logic [NB_W-1:0] open_bins;
	bit finished [NBINS];
	bit below [NBINS];
	bit sign_seen [NBINS];
	logic [CNT_W-1:0] finish_at [NBINS];

	bin_report_t straddle_q [$];
	row_t plan [$];
	int words_in = 0;
	int live_words = 0;
	int errors = 0;
	int src_idle = 16;
	int snk_idle = 47;
	bit hold_rx = 1'b0;

	surrogate_straddle_tracker_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int bins_in_use();
		if (reg_num_bins == 0)
			return 1;
		if (reg_num_bins > NBINS)
			return NBINS;
		return reg_num_bins;
	endfunction

	function automatic bit halted();
		return (surr_count >= reg_max_surr) || (open_bins == 0);
	endfunction

	function automatic void restart_pair();
		surr_count = '0;
		open_bins = NB_W'(bins_in_use());
		foreach (finished[i]) begin
			finished[i] = 1'b0;
			finish_at[i] = '0;
		end
	endfunction

	// A pending bin on a later surrogate compares against its recorded side, which must exist.
	function automatic bit reads_unset_sign(int bin);
		return bin < bins_in_use() && !halted() && surr_count != 0 && !finished[bin]
			&& !sign_seen[bin];
	endfunction

	function automatic void follow_word(input logic cmd, input int bin, input int dat,
			input int sur, input logic last, output bin_report_t r, output bit live);
		bit in_range;
		bit hit;
		logic [CNT_W-1:0] n;
		r = '0;
		live = 1'b0;
		if (cmd == CMD_CLEAR) begin
			restart_pair();
			live = 1'b1;
		end else begin
			in_range = bin < bins_in_use();
			if (halted()) begin
				if (in_range && finished[bin]) begin
					r.bin_state = BS_DONE;
					r.number = finish_at[bin];
				end
			end else begin
				live = in_range;
				n = (surr_count == COUNT_TOP) ? surr_count : surr_count + 1'b1;
				if (in_range && finished[bin]) begin
					r.bin_state = BS_DONE;
					r.number = finish_at[bin];
				end else if (in_range) begin
					if (surr_count == 0) begin
						hit = (sur == dat);
						if (!hit) begin
							below[bin] = (sur < dat);
							sign_seen[bin] = 1'b1;
						end
					end else if (below[bin]) begin
						hit = (sur >= dat);
					end else begin
						hit = (sur <= dat);
					end
					if (hit) begin
						finished[bin] = 1'b1;
						finish_at[bin] = n;
						if (open_bins != 0)
							open_bins = open_bins - 1'b1;
						r.bin_state = BS_STRADDLED;
						r.number = n;
					end
				end
				if (last && surr_count != COUNT_TOP)
					surr_count = surr_count + 1'b1;
			end
		end
		r.pending = open_bins;
		r.all_done = (open_bins == 0);
		r.limit = (surr_count >= reg_max_surr);
	endfunction

	function automatic void flag_error(string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endfunction

	function automatic row_t word_row(logic cmd, int bin, int dat, int sur, logic last);
		row_t w;
		w.kind = ROW_WORD;
		w.reg_sel = REG_NUM_BINS;
		w.reg_val = '0;
		w.cmd = cmd;
		w.bin = bin;
		w.dat = dat;
		w.sur = sur;
		w.last = last;
		w.typed = 1'b0;
		w.want = '0;
		return w;
	endfunction

	function automatic row_t known_row(logic cmd, int bin, int dat, int sur, logic last,
			logic [1:0] st, int num, int pend, logic done, logic lim);
		row_t w;
		w = word_row(cmd, bin, dat, sur, last);
		w.typed = 1'b1;
		w.want.bin_state = st;
		w.want.number = CNT_W'(num);
		w.want.pending = NB_W'(pend);
		w.want.all_done = done;
		w.want.limit = lim;
		return w;
	endfunction

	function automatic row_t reg_row(logic sel, int val);
		row_t w;
		w = word_row(CMD_CLEAR, 0, 0, 0, 1'b0);
		w.kind = ROW_REG;
		w.reg_sel = sel;
		w.reg_val = CNT_W'(val);
		return w;
	endfunction

	task automatic send_word(input logic cmd, input int bin, input int dat, input int sur,
			input logic last, input bit typed, input bin_report_t want);
		bin_report_t r;
		bit live;
		logic c;
		c = cmd;
		if (c == CMD_SAMPLE && reads_unset_sign(bin))
			c = CMD_CLEAR;
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c;
		s_tlast <= last;
		s_tdata <= {6'b0, VAL_W'(sur), VAL_W'(dat), BIN_W'(bin)};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_in++;
		follow_word(c, bin, dat, sur, last, r, live);
		if (live)
			live_words++;
		straddle_q.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [CNT_W-1:0] val);
		s_tvalid <= 1'b0;
		while (straddle_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (sel)
			REG_NUM_BINS: begin
				reg_num_bins = val[NB_W-1:0];
				restart_pair();
			end
			REG_MAX_SURR: begin
				reg_max_surr = val;
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_word();
		send_word($urandom_range(9) == 0 ? CMD_CLEAR : CMD_SAMPLE, $urandom_range(NBINS - 1),
			$urandom_range(VAL_TOP), $urandom_range(VAL_TOP), $urandom_range(4) == 0,
			1'b0, '0);
	endtask

	// One pair: settings, then surrogate sweeps over the bins in order, with some noise.
	task automatic run_pair();
		int nb;
		int mx;
		int sweep;
		int passes;
		int r;
		int dv;
		int sv;
		logic lst;
		int base [64];
		r = $urandom_range(99);
		if (r < 70)
			nb = $urandom_range(1, 6);
		else if (r < 90)
			nb = $urandom_range(7, 40);
		else if (r < 95)
			nb = $urandom_range(1) ? 0 : 2047;
		else
			nb = $urandom_range(41, NBINS);
		if ($urandom_range(99) < 80)
			write_reg(REG_NUM_BINS, CNT_W'(($urandom_range(63) << NB_W) | nb));
		else
			send_word(CMD_CLEAR, $urandom_range(NBINS - 1), $urandom_range(VAL_TOP),
				$urandom_range(VAL_TOP), $urandom_range(1), 1'b0, '0);
		r = $urandom_range(99);
		if (r < 40)
			mx = $urandom_range(1, 6);
		else if (r < 70)
			mx = $urandom_range(7, 20);
		else if (r < 90)
			mx = COUNT_TOP;
		else
			mx = $urandom_range(COUNT_TOP);
		if ($urandom_range(99) < 70)
			write_reg(REG_MAX_SURR, CNT_W'(mx));
		sweep = (bins_in_use() > 40) ? $urandom_range(1, 16) : bins_in_use();
		foreach (base[i]) begin
			r = $urandom_range(9);
			base[i] = (r < 5) ? $urandom_range(VAL_TOP) :
				(r < 9) ? $urandom_range(7) : ($urandom_range(1) ? VAL_TOP : 0);
		end
		passes = $urandom_range(1, 12);
		for (int s = 0; s < passes && !halted(); s++) begin
			for (int b = 0; b < sweep; b++) begin
				r = $urandom_range(99);
				lst = (b == sweep - 1) ^ ($urandom_range(99) < 3);
				if (r < 4) begin
					random_word();
				end else if (r >= 6) begin
					dv = base[b];
					if ($urandom_range(9) == 0)
						sv = $urandom_range(VAL_TOP);
					else
						sv = dv + int'($urandom_range(8)) - 4;
					if (sv < 0)
						sv = 0;
					if (sv > VAL_TOP)
						sv = VAL_TOP;
					send_word(CMD_SAMPLE, b, dv, sv, lst, 1'b0, '0);
				end
			end
		end
		repeat ($urandom_range(3))
			send_word(CMD_SAMPLE, $urandom_range(sweep - 1), $urandom_range(VAL_TOP),
				$urandom_range(VAL_TOP), $urandom_range(1), 1'b0, '0);
	endtask

	always @(negedge clk)
		m_tready <= hold_rx ? 1'b0 : ($urandom_range(99) >= snk_idle);

	always @(posedge clk) begin : result_check
		bin_report_t want;
		if (m_tvalid && m_tready) begin
			if (straddle_q.size() == 0) begin
				flag_error($sformatf("unexpected result word %h", m_tdata));
			end else begin
				want = straddle_q.pop_front();
				if (m_tdata[1:0] !== want.bin_state || m_tdata[18:2] !== want.number
						|| m_tdata[29:19] !== want.pending || m_tdata[30] !== want.all_done
						|| m_tdata[31] !== want.limit)
					flag_error($sformatf({"result mismatch: expected state %0d number %0d ",
						"pending %0d done %0b limit %0b, got state %0d number %0d ",
						"pending %0d done %0b limit %0b"},
						want.bin_state, want.number, want.pending, want.all_done, want.limit,
						m_tdata[1:0], m_tdata[18:2], m_tdata[29:19], m_tdata[30],
						m_tdata[31]));
			end
		end
	end

	// The receiver stops for a long stretch so that the core fills and stalls its input.
	initial begin
		wait (words_in >= 260);
		@(posedge clk);
		hold_rx = 1'b1;
		repeat (150) @(posedge clk);
		hold_rx = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		reg_num_bins = NUM_BINS_RST;
		reg_max_surr = MAX_SURR_RST;
		restart_pair();
		foreach (sign_seen[i]) begin
			sign_seen[i] = 1'b0;
			below[i] = 1'b0;
		end

		plan.push_back(known_row(CMD_SAMPLE, 0, 5, 5, 1'b0, BS_STRADDLED, 1, 1023, 1'b0, 1'b0));
		plan.push_back(known_row(CMD_CLEAR, 1023, VAL_TOP, VAL_TOP, 1'b1,
			BS_PENDING, 0, 1024, 1'b0, 1'b0));
		plan.push_back(reg_row(REG_NUM_BINS, 4));
		plan.push_back(reg_row(REG_MAX_SURR, 3));
		plan.push_back(word_row(CMD_SAMPLE, 0, 0, 0, 1'b0));
		plan.push_back(word_row(CMD_SAMPLE, 1, VAL_TOP, 0, 1'b0));
		plan.push_back(word_row(CMD_SAMPLE, 2, 0, VAL_TOP, 1'b0));
		plan.push_back(word_row(CMD_SAMPLE, 3, 100, 99, 1'b0));
		plan.push_back(known_row(CMD_SAMPLE, 5, 7, 9, 1'b1, BS_PENDING, 0, 3, 1'b0, 1'b0));
		plan.push_back(word_row(CMD_SAMPLE, 0, 8, 1, 1'b0));
		plan.push_back(word_row(CMD_SAMPLE, 1, VAL_TOP, VAL_TOP, 1'b0));
		plan.push_back(word_row(CMD_SAMPLE, 2, 5, 6, 1'b0));
		plan.push_back(word_row(CMD_SAMPLE, 3, 100, 99, 1'b1));
		plan.push_back(word_row(CMD_SAMPLE, 2, 7, 7, 1'b0));
		plan.push_back(word_row(CMD_SAMPLE, 3, 1, 0, 1'b1));
		plan.push_back(known_row(CMD_SAMPLE, 3, 0, 0, 1'b1, BS_PENDING, 0, 1, 1'b0, 1'b1));
		plan.push_back(word_row(CMD_SAMPLE, 1, 3, 3, 1'b0));
		plan.push_back(word_row(CMD_SAMPLE, 1023, 0, VAL_TOP, 1'b1));
		plan.push_back(reg_row(REG_MAX_SURR, COUNT_TOP));
		plan.push_back(word_row(CMD_SAMPLE, 3, 0, 0, 1'b0));
		plan.push_back(known_row(CMD_SAMPLE, 0, 2, 9, 1'b1, BS_DONE, 1, 0, 1'b1, 1'b0));
		plan.push_back(known_row(CMD_CLEAR, 0, 0, 0, 1'b0, BS_PENDING, 0, 4, 1'b0, 1'b0));
		plan.push_back(reg_row(REG_NUM_BINS, 0));
		plan.push_back(reg_row(REG_MAX_SURR, 0));
		plan.push_back(known_row(CMD_SAMPLE, 0, 1, 2, 1'b1, BS_PENDING, 0, 1, 1'b0, 1'b1));
		plan.push_back(reg_row(REG_MAX_SURR, 1));
		plan.push_back(word_row(CMD_SAMPLE, 0, 5, 3, 1'b1));
		plan.push_back(reg_row(REG_NUM_BINS, COUNT_TOP));
		plan.push_back(known_row(CMD_SAMPLE, 1023, VAL_TOP, VAL_TOP, 1'b1,
			BS_STRADDLED, 1, 1023, 1'b0, 1'b1));
		plan.push_back(known_row(CMD_SAMPLE, 1023, 0, 1, 1'b0, BS_DONE, 1, 1023, 1'b0, 1'b1));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG)
				write_reg(plan[i].reg_sel, plan[i].reg_val);
			else
				send_word(plan[i].cmd, plan[i].bin, plan[i].dat, plan[i].sur, plan[i].last,
					plan[i].typed, plan[i].want);
		end

		for (int phase = 0; phase < 3; phase++) begin
			src_idle = (phase == 0) ? 16 : (phase == 1) ? 47 : 0;
			snk_idle = (phase == 0) ? 47 : (phase == 1) ? 16 : 0;
			for (int goal = live_words + 267; live_words < goal; )
				run_pair();
		end
		s_tvalid <= 1'b0;

		while (straddle_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && straddle_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- sim.f -----
src/sst_pkg.sv
src/sst_front.sv
src/sst_back.sv
src/surrogate_straddle_tracker_core.sv
dv/surrogate_straddle_tracker_core_tb.sv
